// File: hw/rtl/bubble_sort_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bubble sort engine
// Clocked on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BUBBLE_SORT_ENGINE_ASSERT_SVH
`define BUBBLE_SORT_ENGINE_ASSERT_SVH

// Same-cycle implication: the consequent holds whenever the antecedent does.
`define BSE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: the consequent holds in the cycle after the antecedent.
`define BSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants of the bubble sort engine.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] data_t;

  // Input request: one element of the set.
  typedef struct packed {
    data_t value;
    logic  is_last;
  } in_req_t;

  // Output request: one sorted element.
  typedef struct packed {
    data_t sorted_value;
    logic  is_last_res;
  } out_req_t;

  // Compare-and-swap result: the element to leave behind and the one to carry.
  typedef struct packed {
    data_t low;
    data_t high;
  } cs_res_t;

endpackage

// File: hw/rtl/bubble_sort_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bubble_sort_engine
// Collects a set of signed 32-bit elements and returns it in ascending order.
// ----------------------------------------------------------------------------
// Elements arrive one per input request; the request with is_last set closes
// the set. Up to MAX_ITEMS elements are kept, further ones are dropped, but a
// closing request still closes the set. The set is then ordered with bubble
// sort: one signed comparator walks the store once per pass, carrying the
// larger element toward the top, and each pass is one entry shorter. Equal
// elements are never swapped. Loading accepts one element per cycle while
// in_valid_i is high; sorting a set of n elements takes n-1 passes, each
// stepping through address, prime, its compares and write-back, one compare
// at a time, set by the single comparator and the single read port of the
// store; emitting reads each result from the store and holds it until the
// consumer takes it. Input is not ready from the closing element until the
// last result has been taken.
// ----------------------------------------------------------------------------
`include "bubble_sort_engine_assert.svh"

module bubble_sort_engine #(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bse_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bse_pkg::out_req_t  out_req_o
);

  localparam int unsigned IdxW = $clog2(MAX_ITEMS);
  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ITEMS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_LOAD,
    S_RUN,
    S_FLUSH,
    S_E_ADDR,
    S_E_LOAD,
    S_E_WAIT
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic [IdxW-1:0]   limit_q;
  logic [IdxW-1:0]   j_q;
  logic [IdxW-1:0]   k_q;
  bse_pkg::data_t    cur_q;
  logic              out_valid_q;
  bse_pkg::out_req_t out_req_q;

  // Store: one write and one registered read per cycle.
  bse_pkg::data_t    mem_q [MAX_ITEMS];
  bse_pkg::data_t    rdata_q;
  logic              we;
  logic [IdxW-1:0]   waddr;
  bse_pkg::data_t    wdata;
  logic [IdxW-1:0]   raddr;

  logic              in_fire;
  logic              out_fire;
  logic              has_room;
  logic [CntW-1:0]   n_next;
  logic [IdxW-1:0]   jp1;
  logic              k_last;
  bse_pkg::cs_res_t  cs_res;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;
  assign out_fire    = out_valid_q && out_ready_i;

  assign has_room = (count_q < MaxCnt);
  assign n_next   = count_q + CntW'(has_room);
  assign jp1      = j_q + IdxW'(1);
  assign k_last   = (k_q == IdxW'(count_q - CntW'(1)));

  // Shared comparator: carried element against the element just read.
  bse_cmp_swap u_cmp_swap (
    .carry_i (cur_q),
    .next_i  (rdata_q),
    .res_o   (cs_res)
  );

  // Store port selection.
  always_comb begin
    we    = 1'b0;
    waddr = j_q;
    wdata = cs_res.low;
    raddr = '0;
    case (state_q)
      S_IDLE: begin
        // Drop elements once the store is full.
        we    = in_fire && has_room;
        waddr = count_q[IdxW-1:0];
        wdata = in_req_i.value;
      end
      S_LOAD: begin
        raddr = IdxW'(1);
      end
      S_RUN: begin
        // Leave the smaller element behind; fetch two ahead.
        we    = 1'b1;
        raddr = jp1 + IdxW'(1);
      end
      S_FLUSH: begin
        // The carried element is the largest of this pass.
        we    = 1'b1;
        waddr = limit_q;
        wdata = cur_q;
      end
      S_E_ADDR: begin
        raddr = k_q;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      limit_q     <= '0;
      j_q         <= '0;
      k_q         <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      out_req_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            count_q <= n_next;
            if (in_req_i.is_last) begin
              limit_q <= IdxW'(n_next - CntW'(1));
              k_q     <= '0;
              // A single element needs no pass.
              state_q <= (n_next > CntW'(1)) ? S_PRIME : S_E_ADDR;
            end
          end
        end
        S_PRIME: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          // Entry 0 becomes the carried element.
          cur_q   <= rdata_q;
          j_q     <= '0;
          state_q <= S_RUN;
        end
        S_RUN: begin
          cur_q <= cs_res.high;
          if (jp1 == limit_q) begin
            state_q <= S_FLUSH;
          end else begin
            j_q <= jp1;
          end
        end
        S_FLUSH: begin
          if (limit_q == IdxW'(1)) begin
            state_q <= S_E_ADDR;
          end else begin
            limit_q <= limit_q - IdxW'(1);
            state_q <= S_PRIME;
          end
        end
        S_E_ADDR: begin
          state_q <= S_E_LOAD;
        end
        S_E_LOAD: begin
          out_req_q.sorted_value <= rdata_q;
          out_req_q.is_last_res  <= k_last;
          out_valid_q            <= 1'b1;
          state_q                <= S_E_WAIT;
        end
        S_E_WAIT: begin
          // Hold the result until it is taken.
          if (out_fire) begin
            out_valid_q <= 1'b0;
            if (out_req_q.is_last_res) begin
              count_q <= '0;
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + IdxW'(1);
              state_q <= S_E_ADDR;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `BSE_ASSERT(a_no_overlap, in_ready_o, !out_valid_o, "input ready while a result is pending")
  `BSE_ASSERT(a_count_bound, 1'b1, count_q <= MaxCnt, "element count beyond store capacity")
  `BSE_ASSERT(a_run_index, state_q == S_RUN, j_q < limit_q, "compare index beyond pass length")
  `BSE_ASSERT_NEXT(a_last_idle, out_fire && out_req_o.is_last_res, in_ready_o && count_q == '0, "engine not idle after final result")

endmodule

// File: hw/rtl/bse_cmp_swap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_cmp_swap
// Signed compare-and-swap of the carried element against the next element.
// ----------------------------------------------------------------------------
module bse_cmp_swap (
  input  bse_pkg::data_t  carry_i,
  input  bse_pkg::data_t  next_i,
  output bse_pkg::cs_res_t res_o
);

  logic swap;

  // Swap only on strictly greater, so equal elements keep their order.
  assign swap      = carry_i > next_i;
  assign res_o.low  = swap ? next_i  : carry_i;
  assign res_o.high = swap ? carry_i : next_i;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: bubble sort engine testbench
// Loads sets of signed 32-bit elements through the input request channel and
// checks each sorted output request against a queue of expected elements
// that is built by an independent ascending sort of each closed set. Both
// channels stall at random, with one calm stretch and three full drains.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned Capacity  = 32;
  localparam int unsigned ElemGoal  = 500;
  localparam int unsigned CycleCap  = 400_000;
  localparam int unsigned DrainWait = 40;
  localparam int unsigned IdlePct   = 38;

  // Track the set being loaded and the sorted elements still owed.
  class sorted_set_board;
    bse_pkg::data_t    open_set[$];
    bse_pkg::out_req_t owed_sorted[$];
    int                mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Store the element unless the set is full; on the closing element,
    // sort the set ascending (stable) and queue one result per element.
    function void note_element(bse_pkg::in_req_t req);
      bse_pkg::data_t    ordered[$];
      bse_pkg::data_t    held;
      bse_pkg::out_req_t res;
      if (open_set.size() < Capacity) open_set.push_back(req.value);
      if (!req.is_last) return;
      ordered = open_set;
      for (int pass = 1; pass < ordered.size(); pass++) begin
        for (int j = 0; j + pass < ordered.size(); j++) begin
          if (ordered[j] > ordered[j+1]) begin
            held         = ordered[j];
            ordered[j]   = ordered[j+1];
            ordered[j+1] = held;
          end
        end
      end
      foreach (ordered[k]) begin
        res.sorted_value = ordered[k];
        res.is_last_res  = (k == ordered.size() - 1);
        owed_sorted.push_back(res);
      end
      open_set.delete();
    endfunction

    function void check_sorted(bse_pkg::out_req_t got);
      bse_pkg::out_req_t want;
      if (owed_sorted.size() == 0) begin
        $error("unexpected result: sorted_value=%0d is_last_res=%0b",
               got.sorted_value, got.is_last_res);
        mismatches++;
        return;
      end
      want = owed_sorted.pop_front();
      if (got.sorted_value !== want.sorted_value) begin
        $error("sorted_value: expected %0d, got %0d", want.sorted_value, got.sorted_value);
        mismatches++;
      end
      if (got.is_last_res !== want.is_last_res) begin
        $error("is_last_res: expected %0b, got %0b", want.is_last_res, got.is_last_res);
        mismatches++;
      end
    endfunction

    function int owed_count();
      return owed_sorted.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  bse_pkg::in_req_t  in_req_i;
  logic              out_valid_o;
  logic              out_ready_i;
  bse_pkg::out_req_t out_req_o;

  sorted_set_board sort_board = new();

  // Suppress random stalls on both sides while calm is high.
  bit          calm;
  int unsigned stored_elems;
  int unsigned cycle_cnt;

  bubble_sort_engine #(
    .MAX_ITEMS(Capacity)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

  // 4 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Count cycles and abort on a hung block.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleCap) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Drive the consumer ready at the falling edge: hold it high during the
  // calm stretch, otherwise drop it with a 38 percent chance at each edge.
  always @(negedge clk_i) begin
    if (calm) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= IdlePct);
    end
  end

  // Check every output request taken at a rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sort_board.check_sorted(out_req_o);
    end
  end

  // Present one input request after idling with a 38 percent chance at each
  // falling edge, and hold it until the block takes it. Valid stays high across
  // back-to-back requests so it is never lowered and raised in one step.
  task automatic push_element(input bse_pkg::data_t value, input logic is_last);
    bse_pkg::in_req_t req;
    req.value   = value;
    req.is_last = is_last;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sort_board.note_element(req);
    if (stored_elems < ElemGoal) stored_elems++;
  endtask

  // Lower valid and wait until every owed result has been taken.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sort_board.owed_count() != 0) @(posedge clk_i);
  endtask

  // Pick a value: bias toward extremes and a narrow band to force ties.
  function automatic bse_pkg::data_t pick_value();
    int unsigned mode;
    mode = $urandom_range(9);
    case (mode)
      0: begin
        return bse_pkg::data_t'(32'h8000_0000);
      end
      1: begin
        return bse_pkg::data_t'(32'h7FFF_FFFF);
      end
      2, 3: begin
        return bse_pkg::data_t'($signed($urandom_range(16)) - 8);
      end
      default: begin
        return bse_pkg::data_t'($urandom);
      end
    endcase
  endfunction

  // Send one closed set of the given length; lengths past the capacity
  // drop the tail, but the closing element still closes the set.
  task automatic push_set(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      push_element(pick_value(), i == len - 1);
    end
  endtask

  initial begin
    bse_pkg::data_t edge_vals[$];
    int unsigned    len;
    int unsigned    roll;
    bit             drained_mid;

    calm         = 1'b0;
    stored_elems = 0;
    cycle_cnt    = 0;
    drained_mid  = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_req_i     = '0;
    out_ready_i  = 1'b0;

    // Hold reset low, then release it at a falling edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed sets: single element, both extremes, mixed signs, ties,
    // already ordered and reversed input.
    push_element(bse_pkg::data_t'(32'h7FFF_FFFF), 1'b1);
    push_element(bse_pkg::data_t'(32'h7FFF_FFFF), 1'b0);
    push_element(bse_pkg::data_t'(32'h8000_0000), 1'b1);
    edge_vals = '{bse_pkg::data_t'(32'h8000_0000), bse_pkg::data_t'(32'h7FFF_FFFF),
                  bse_pkg::data_t'(0), bse_pkg::data_t'(-1), bse_pkg::data_t'(1)};
    foreach (edge_vals[i]) push_element(edge_vals[i], i == edge_vals.size() - 1);
    edge_vals = '{bse_pkg::data_t'(5), bse_pkg::data_t'(-5), bse_pkg::data_t'(5),
                  bse_pkg::data_t'(-5)};
    foreach (edge_vals[i]) push_element(edge_vals[i], i == edge_vals.size() - 1);
    edge_vals = '{bse_pkg::data_t'(1), bse_pkg::data_t'(2), bse_pkg::data_t'(3)};
    foreach (edge_vals[i]) push_element(edge_vals[i], i == edge_vals.size() - 1);
    edge_vals = '{bse_pkg::data_t'(3), bse_pkg::data_t'(2), bse_pkg::data_t'(1)};
    foreach (edge_vals[i]) push_element(edge_vals[i], i == edge_vals.size() - 1);

    // Pause the sender until every owed result has arrived.
    drain_results();

    // Random sets: mostly short, some mid-size, a few exactly full or
    // overfull so the closing element lands on a full store.
    while (stored_elems < ElemGoal) begin
      calm = (stored_elems >= 200 && stored_elems < 300);
      roll = $urandom_range(99);
      if (roll < 70) begin
        len = $urandom_range(1, 8);
      end else if (roll < 90) begin
        len = $urandom_range(9, Capacity - 1);
      end else if (roll < 95) begin
        len = Capacity;
      end else begin
        len = $urandom_range(Capacity + 1, Capacity + 8);
      end
      push_set(len);
      if (!drained_mid && stored_elems >= 350) begin
        drain_results();
        drained_mid = 1'b1;
      end
    end
    calm = 1'b0;

    // Drain and let the block settle before the verdict.
    drain_results();
    repeat (DrainWait) @(posedge clk_i);

    if (sort_board.mismatches == 0 && sort_board.owed_count() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/bse_pkg.sv
hw/rtl/bse_cmp_swap.sv
hw/rtl/bubble_sort_engine.sv
bench/tb.sv
